### hdl/rra_pkg.sv
// Package for the rumble request arbiter: sizes, command and register codes,
// the entry format and the controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rra_pkg;

  localparam int ENTRIES = 8;
  localparam int MOTORS  = 2;
  localparam int NREP    = (MOTORS < 2) ? MOTORS : 2;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int MOT_W   = (MOTORS > 1) ? $clog2(MOTORS) : 1;
  localparam int ADDR_W  = MOT_W + IDX_W;
  localparam int DEPTH   = 2 ** ADDR_W;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUPPRESS = 1'b1;
  localparam logic       ENABLE_RST   = 1'b1;
  localparam logic [7:0] SUPPRESS_RST = 8'hFF;

  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE       = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD       = 5'd1;
  localparam logic [OP_W-1:0] OP_STOP       = 5'd2;
  localparam logic [OP_W-1:0] OP_ACCEPT     = 5'd3;
  localparam logic [OP_W-1:0] OP_SCAN_INIT  = 5'd4;
  localparam logic [OP_W-1:0] OP_IDX_INC    = 5'd5;
  localparam logic [OP_W-1:0] OP_PUT        = 5'd6;
  localparam logic [OP_W-1:0] OP_APPEND     = 5'd7;
  localparam logic [OP_W-1:0] OP_WEAK_EVAL  = 5'd8;
  localparam logic [OP_W-1:0] OP_MOVE       = 5'd9;
  localparam logic [OP_W-1:0] OP_MOT_INC    = 5'd10;
  localparam logic [OP_W-1:0] OP_SEL_EVAL   = 5'd11;
  localparam logic [OP_W-1:0] OP_SEL_STORE  = 5'd12;
  localparam logic [OP_W-1:0] OP_EMIT       = 5'd13;
  localparam logic [OP_W-1:0] OP_EXP_INIT   = 5'd14;
  localparam logic [OP_W-1:0] OP_EXP_HIT    = 5'd15;
  localparam logic [OP_W-1:0] OP_EXP_MOVE   = 5'd16;
  localparam logic [OP_W-1:0] OP_IDX_DEC    = 5'd17;
  localparam logic [OP_W-1:0] OP_CLR_STOP   = 5'd18;

  typedef struct packed {
    logic [31:0] start;
    logic [15:0] dur;
    logic [7:0]  level;
    logic        script;
  } entry_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } ctrl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       start_ok;
    logic       script;
    logic       cnt_zero;
    logic       cnt_full;
    logic       idx_last;
    logic       idx_zero;
    logic       sel_zero;
    logic       rd_script;
    logic       expired;
    logic       weak_take;
    logic       mot_last_rep;
    logic       mot_last_all;
  } status_t;

endpackage
`default_nettype wire

### hdl/rumble_request_arbiter_top.sv
// Top level of the rumble request arbiter: joins rra_ctrl and rra_datapath.
// Depends on rra_pkg, rra_ctrl and rra_datapath.
//
// Usage:
//   Input: drive the in_ fields and pulse start while busy is low; the
//   request is taken at that edge and busy stays high until its work ends.
//   Start and stop requests give no result. A tick gives one result per
//   reported motor (motor 0 then motor 1) on consecutive cycles, each marked
//   by out_valid for one cycle, the final one with out_last.
//   Configuration: cfg_ready is always high; write only while busy is low.
//   Index 0 is the enable bit, index 1 the active suppress id.
//   Results of a tick appear after the selection scan. Each stored entry is
//   read through the one registered read port of the entry memory.
//   Reset: counts, hold-off and the stopped flag clear, enable goes to 1 and
//   the suppress id to -1. The entry memory is not cleared.
//   The receiver cannot stall; results are never held.
`timescale 1ns / 1ps
`default_nettype none
module rumble_request_arbiter_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    in_command,
  input  wire logic [31:0]                   in_time_ms,
  input  wire logic [15:0]                   in_heavy_duration,
  input  wire logic [7:0]                    in_heavy_level,
  input  wire logic [15:0]                   in_light_duration,
  input  wire logic [7:0]                    in_light_level,
  input  wire logic [15:0]                   in_hold_off_ms,
  input  wire logic signed [7:0]             in_request_suppress_id,
  input  wire logic                          in_script_request,
  input  wire logic                          in_blocked,
  input  wire logic                          in_force_stop,
  output logic                               out_valid,
  output logic                               out_motor,
  output logic [7:0]                         out_drive_level,
  output logic                               out_shaking,
  output logic                               out_last,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                    cfg_data
);

  rra_pkg::ctrl_t   ctrl;
  rra_pkg::status_t stat;
  logic             go;

  assign cfg_ready = 1'b1;
  assign go        = start && !busy;

  rra_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (go),
    .stat  (stat),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  rra_datapath u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .ctrl                   (ctrl),
    .stat                   (stat),
    .cfg_we                 (cfg_valid && cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .in_command             (in_command),
    .in_time_ms             (in_time_ms),
    .in_heavy_duration      (in_heavy_duration),
    .in_heavy_level         (in_heavy_level),
    .in_light_duration      (in_light_duration),
    .in_light_level         (in_light_level),
    .in_hold_off_ms         (in_hold_off_ms),
    .in_request_suppress_id (in_request_suppress_id),
    .in_script_request      (in_script_request),
    .in_blocked             (in_blocked),
    .in_force_stop          (in_force_stop),
    .out_valid              (out_valid),
    .out_motor              (out_motor),
    .out_drive_level        (out_drive_level),
    .out_shaking            (out_shaking),
    .out_last               (out_last)
  );

endmodule
`default_nettype wire

### hdl/rra_ctrl.sv
// Sequencer for the rumble request arbiter: walks start, tick and stop work.
// Depends on rra_pkg; drives rra_datapath through ctrl_t, reads status_t.
`timescale 1ns / 1ps
`default_nettype none
module rra_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire rra_pkg::status_t stat,
  output logic                 busy,
  output rra_pkg::ctrl_t       ctrl
);

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_DISP    = 5'd1;
  localparam logic [4:0] ST_REQ     = 5'd2;
  localparam logic [4:0] ST_S_RD    = 5'd3;
  localparam logic [4:0] ST_S_EV    = 5'd4;
  localparam logic [4:0] ST_PLACE   = 5'd5;
  localparam logic [4:0] ST_W_RD    = 5'd6;
  localparam logic [4:0] ST_W_EV    = 5'd7;
  localparam logic [4:0] ST_W_DEC   = 5'd8;
  localparam logic [4:0] ST_L_RD    = 5'd9;
  localparam logic [4:0] ST_MOVE    = 5'd10;
  localparam logic [4:0] ST_PUT     = 5'd11;
  localparam logic [4:0] ST_NEXTM   = 5'd12;
  localparam logic [4:0] ST_T_SEL   = 5'd13;
  localparam logic [4:0] ST_T_RD    = 5'd14;
  localparam logic [4:0] ST_T_EV    = 5'd15;
  localparam logic [4:0] ST_T_STORE = 5'd16;
  localparam logic [4:0] ST_T_OUT   = 5'd17;
  localparam logic [4:0] ST_X_INIT  = 5'd18;
  localparam logic [4:0] ST_X_RD    = 5'd19;
  localparam logic [4:0] ST_X_EV    = 5'd20;
  localparam logic [4:0] ST_X_LRD   = 5'd21;
  localparam logic [4:0] ST_X_MOVE  = 5'd22;
  localparam logic [4:0] ST_X_NEXT  = 5'd23;

  logic [4:0] st_r, st_nxt;

  assign busy = (st_r != ST_IDLE);

  always_comb begin
    st_nxt  = st_r;
    ctrl.op = rra_pkg::OP_NONE;
    case (st_r)
      ST_IDLE: begin
        if (start) begin
          ctrl.op = rra_pkg::OP_LOAD;
          st_nxt  = ST_DISP;
        end
      end
      ST_DISP: begin
        case (stat.cmd)
          rra_pkg::CMD_START: begin
            if (stat.start_ok) begin
              ctrl.op = rra_pkg::OP_ACCEPT;
              st_nxt  = ST_REQ;
            end else begin
              st_nxt = ST_IDLE;
            end
          end
          rra_pkg::CMD_TICK: st_nxt = ST_T_SEL;
          rra_pkg::CMD_STOP: begin
            ctrl.op = rra_pkg::OP_STOP;
            st_nxt  = ST_IDLE;
          end
          default: st_nxt = ST_IDLE;
        endcase
      end
      ST_REQ: begin
        if (stat.script && !stat.cnt_zero) begin
          ctrl.op = rra_pkg::OP_SCAN_INIT;
          st_nxt  = ST_S_RD;
        end else begin
          st_nxt = ST_PLACE;
        end
      end
      ST_S_RD: st_nxt = ST_S_EV;
      ST_S_EV: begin
        if (stat.rd_script) begin
          ctrl.op = rra_pkg::OP_PUT;
          st_nxt  = ST_NEXTM;
        end else if (stat.idx_last) begin
          st_nxt = ST_PLACE;
        end else begin
          ctrl.op = rra_pkg::OP_IDX_INC;
          st_nxt  = ST_S_RD;
        end
      end
      ST_PLACE: begin
        if (!stat.cnt_full) begin
          ctrl.op = rra_pkg::OP_APPEND;
          st_nxt  = ST_NEXTM;
        end else begin
          ctrl.op = rra_pkg::OP_SCAN_INIT;
          st_nxt  = ST_W_RD;
        end
      end
      ST_W_RD: st_nxt = ST_W_EV;
      ST_W_EV: begin
        ctrl.op = rra_pkg::OP_WEAK_EVAL;
        st_nxt  = stat.idx_last ? ST_W_DEC : ST_W_RD;
      end
      ST_W_DEC: st_nxt = stat.weak_take ? ST_L_RD : ST_NEXTM;
      ST_L_RD:  st_nxt = ST_MOVE;
      ST_MOVE: begin
        ctrl.op = rra_pkg::OP_MOVE;
        st_nxt  = ST_PUT;
      end
      ST_PUT: begin
        ctrl.op = rra_pkg::OP_PUT;
        st_nxt  = ST_NEXTM;
      end
      ST_NEXTM: begin
        if (stat.mot_last_rep) begin
          st_nxt = ST_IDLE;
        end else begin
          ctrl.op = rra_pkg::OP_MOT_INC;
          st_nxt  = ST_REQ;
        end
      end
      ST_T_SEL: begin
        ctrl.op = rra_pkg::OP_SCAN_INIT;
        st_nxt  = stat.cnt_zero ? ST_T_STORE : ST_T_RD;
      end
      ST_T_RD: st_nxt = ST_T_EV;
      ST_T_EV: begin
        ctrl.op = rra_pkg::OP_SEL_EVAL;
        st_nxt  = (stat.rd_script || stat.idx_last) ? ST_T_STORE : ST_T_RD;
      end
      ST_T_STORE: begin
        ctrl.op = rra_pkg::OP_SEL_STORE;
        st_nxt  = stat.mot_last_rep ? ST_T_OUT : ST_T_SEL;
      end
      ST_T_OUT: begin
        ctrl.op = rra_pkg::OP_EMIT;
        st_nxt  = stat.mot_last_rep ? ST_X_INIT : ST_T_OUT;
      end
      ST_X_INIT: begin
        ctrl.op = rra_pkg::OP_EXP_INIT;
        st_nxt  = stat.cnt_zero ? ST_X_NEXT : ST_X_RD;
      end
      ST_X_RD: st_nxt = ST_X_EV;
      ST_X_EV: begin
        if (stat.expired) begin
          ctrl.op = rra_pkg::OP_EXP_HIT;
          st_nxt  = ST_X_LRD;
        end else if (stat.idx_zero) begin
          st_nxt = ST_X_NEXT;
        end else begin
          ctrl.op = rra_pkg::OP_IDX_DEC;
          st_nxt  = ST_X_RD;
        end
      end
      ST_X_LRD: st_nxt = ST_X_MOVE;
      ST_X_MOVE: begin
        ctrl.op = rra_pkg::OP_EXP_MOVE;
        st_nxt  = stat.sel_zero ? ST_X_NEXT : ST_X_RD;
      end
      ST_X_NEXT: begin
        if (stat.mot_last_all) begin
          ctrl.op = rra_pkg::OP_CLR_STOP;
          st_nxt  = ST_IDLE;
        end else begin
          ctrl.op = rra_pkg::OP_MOT_INC;
          st_nxt  = ST_X_INIT;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE && start) |=> (st_r == ST_DISP))
    else $error("request not taken into dispatch");
  a_emit_end: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_T_OUT && stat.mot_last_rep) |=> (st_r == ST_X_INIT))
    else $error("expiry did not follow last result");
  a_tick_end: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == rra_pkg::OP_CLR_STOP) |=> !busy)
    else $error("tick did not finish");

endmodule
`default_nettype wire

### hdl/rra_datapath.sv
// Datapath for the rumble request arbiter: entry memory, counts, hold-off,
// configuration registers and result registers. Depends on rra_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rra_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rra_pkg::ctrl_t                ctrl,
  output rra_pkg::status_t                   stat,
  input  wire logic                          cfg_we,
  input  wire logic [rra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                    cfg_data,
  input  wire logic [1:0]                    in_command,
  input  wire logic [31:0]                   in_time_ms,
  input  wire logic [15:0]                   in_heavy_duration,
  input  wire logic [7:0]                    in_heavy_level,
  input  wire logic [15:0]                   in_light_duration,
  input  wire logic [7:0]                    in_light_level,
  input  wire logic [15:0]                   in_hold_off_ms,
  input  wire logic signed [7:0]             in_request_suppress_id,
  input  wire logic                          in_script_request,
  input  wire logic                          in_blocked,
  input  wire logic                          in_force_stop,
  output logic                               out_valid,
  output logic                               out_motor,
  output logic [7:0]                         out_drive_level,
  output logic                               out_shaking,
  output logic                               out_last
);

  localparam int IW = rra_pkg::IDX_W;
  localparam int CW = rra_pkg::CNT_W;
  localparam int MW = rra_pkg::MOT_W;

  rra_pkg::entry_t mem [rra_pkg::DEPTH];
  rra_pkg::entry_t rd_r;

  logic [1:0]  cmd_r;
  logic [31:0] now_r;
  logic [15:0] hdur_r, ldur_r, hold_r;
  logic [7:0]  hlev_r, llev_r, rid_r;
  logic        script_r, blocked_r, force_r;

  logic        en_r;
  logic [7:0]  sid_r;
  logic [CW-1:0] cnt_r [rra_pkg::MOTORS];
  logic [CW-1:0] cnt_nxt [rra_pkg::MOTORS];
  logic [31:0] hold_until_r, hold_until_nxt;
  logic [7:0]  hold_level_r, hold_level_nxt;
  logic        stopped_r, stopped_nxt;
  logic [MW-1:0] mot_r, mot_nxt;
  logic [IW-1:0] idx_r, idx_nxt, sel_r, sel_nxt;
  logic        found_r, found_nxt;
  logic [7:0]  blevel_r, blevel_nxt;
  logic [7:0]  lv_r [2];
  logic [7:0]  lv_nxt [2];
  logic        any_r, any_nxt;
  logic        out_valid_r, out_valid_nxt, out_motor_r, out_motor_nxt;
  logic [7:0]  out_level_r, out_level_nxt;
  logic        out_shaking_r, out_shaking_nxt, out_last_r, out_last_nxt;

  logic [CW-1:0] cnt_cur;
  logic [IW-1:0] last_idx;
  logic [7:0]  new_lev;
  logic [15:0] new_dur;
  rra_pkg::entry_t new_entry, wr_data;
  logic        wr_en;
  logic [IW-1:0] wr_idx;
  logic [31:0] end_time;

  assign cnt_cur   = cnt_r[mot_r];
  assign last_idx  = IW'(cnt_cur - CW'(1));
  assign new_lev   = (mot_r == MW'(0)) ? hlev_r : llev_r;
  assign new_dur   = (mot_r == MW'(0)) ? hdur_r : ldur_r;
  assign new_entry = '{start: now_r, dur: new_dur, level: new_lev, script: script_r};
  assign end_time  = rd_r.start + {16'd0, rd_r.dur};

  always_comb begin
    stat.cmd          = cmd_r;
    stat.start_ok     = en_r && !blocked_r && !stopped_r && (rid_r == sid_r) &&
                        !((now_r < hold_until_r) &&
                          (((hlev_r > llev_r) ? hlev_r : llev_r) <= hold_level_r));
    stat.script       = script_r;
    stat.cnt_zero     = (cnt_cur == CW'(0));
    stat.cnt_full     = (cnt_cur == CW'(rra_pkg::ENTRIES));
    stat.idx_last     = ((CW'(idx_r) + CW'(1)) == cnt_cur);
    stat.idx_zero     = (idx_r == IW'(0));
    stat.sel_zero     = (sel_r == IW'(0));
    stat.rd_script    = rd_r.script;
    stat.expired      = (now_r >= end_time);
    stat.weak_take    = found_r && (blevel_r <= new_lev);
    stat.mot_last_rep = (mot_r == MW'(rra_pkg::NREP - 1));
    stat.mot_last_all = (mot_r == MW'(rra_pkg::MOTORS - 1));
  end

  always_comb begin
    cnt_nxt         = cnt_r;
    hold_until_nxt  = hold_until_r;
    hold_level_nxt  = hold_level_r;
    stopped_nxt     = stopped_r;
    mot_nxt         = mot_r;
    idx_nxt         = idx_r;
    sel_nxt         = sel_r;
    found_nxt       = found_r;
    blevel_nxt      = blevel_r;
    lv_nxt          = lv_r;
    any_nxt         = any_r;
    out_valid_nxt   = 1'b0;
    out_motor_nxt   = out_motor_r;
    out_level_nxt   = out_level_r;
    out_shaking_nxt = out_shaking_r;
    out_last_nxt    = out_last_r;
    wr_en           = 1'b0;
    wr_idx          = idx_r;
    wr_data         = new_entry;
    case (ctrl.op)
      rra_pkg::OP_LOAD: begin
        mot_nxt = '0;
        any_nxt = 1'b0;
      end
      rra_pkg::OP_STOP: begin
        for (int m = 0; m < rra_pkg::MOTORS; m++) begin
          cnt_nxt[m] = '0;
        end
        if (force_r) begin
          stopped_nxt = 1'b1;
        end
      end
      rra_pkg::OP_ACCEPT: begin
        hold_until_nxt = now_r + {16'd0, hold_r};
        hold_level_nxt = (hlev_r > llev_r) ? hlev_r : llev_r;
        mot_nxt        = '0;
      end
      rra_pkg::OP_SCAN_INIT: begin
        idx_nxt    = '0;
        found_nxt  = 1'b0;
        blevel_nxt = '0;
      end
      rra_pkg::OP_IDX_INC: idx_nxt = idx_r + IW'(1);
      rra_pkg::OP_IDX_DEC: idx_nxt = idx_r - IW'(1);
      rra_pkg::OP_PUT: wr_en = 1'b1;
      rra_pkg::OP_APPEND: begin
        wr_en          = 1'b1;
        wr_idx         = IW'(cnt_cur);
        cnt_nxt[mot_r] = cnt_cur + CW'(1);
      end
      rra_pkg::OP_WEAK_EVAL: begin
        if (!rd_r.script && (!found_r || rd_r.level < blevel_r)) begin
          found_nxt  = 1'b1;
          blevel_nxt = rd_r.level;
          sel_nxt    = idx_r;
        end
        if (!stat.idx_last) begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      rra_pkg::OP_MOVE: begin
        wr_en   = 1'b1;
        wr_idx  = sel_r;
        wr_data = rd_r;
      end
      rra_pkg::OP_MOT_INC: mot_nxt = mot_r + MW'(1);
      rra_pkg::OP_SEL_EVAL: begin
        if (rd_r.script || rd_r.level >= blevel_r) begin
          found_nxt  = 1'b1;
          blevel_nxt = rd_r.level;
        end
        if (!rd_r.script && !stat.idx_last) begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      rra_pkg::OP_SEL_STORE: begin
        lv_nxt[mot_r[0]] = blevel_r;
        any_nxt          = any_r | found_r;
        mot_nxt          = stat.mot_last_rep ? MW'(0) : mot_r + MW'(1);
      end
      rra_pkg::OP_EMIT: begin
        out_valid_nxt   = 1'b1;
        out_motor_nxt   = mot_r[0];
        out_level_nxt   = lv_r[mot_r[0]];
        out_shaking_nxt = any_r;
        out_last_nxt    = stat.mot_last_rep;
        mot_nxt         = stat.mot_last_rep ? MW'(0) : mot_r + MW'(1);
      end
      rra_pkg::OP_EXP_INIT: idx_nxt = last_idx;
      rra_pkg::OP_EXP_HIT: begin
        sel_nxt = idx_r;
        idx_nxt = last_idx;
      end
      rra_pkg::OP_EXP_MOVE: begin
        wr_en          = 1'b1;
        wr_idx         = sel_r;
        wr_data        = rd_r;
        cnt_nxt[mot_r] = cnt_cur - CW'(1);
        idx_nxt        = sel_r - IW'(1);
      end
      rra_pkg::OP_CLR_STOP: stopped_nxt = 1'b0;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{mot_r, wr_idx}] <= wr_data;
    end
    rd_r <= mem[{mot_r, idx_r}];
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == rra_pkg::OP_LOAD) begin
      cmd_r     <= in_command;
      now_r     <= in_time_ms;
      hdur_r    <= in_heavy_duration;
      hlev_r    <= in_heavy_level;
      ldur_r    <= in_light_duration;
      llev_r    <= in_light_level;
      hold_r    <= in_hold_off_ms;
      rid_r     <= in_request_suppress_id;
      script_r  <= in_script_request;
      blocked_r <= in_blocked;
      force_r   <= in_force_stop;
    end
    idx_r         <= idx_nxt;
    sel_r         <= sel_nxt;
    found_r       <= found_nxt;
    blevel_r      <= blevel_nxt;
    lv_r          <= lv_nxt;
    any_r         <= any_nxt;
    out_motor_r   <= out_motor_nxt;
    out_level_r   <= out_level_nxt;
    out_shaking_r <= out_shaking_nxt;
    out_last_r    <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r         <= rra_pkg::ENABLE_RST;
      sid_r        <= rra_pkg::SUPPRESS_RST;
      for (int m = 0; m < rra_pkg::MOTORS; m++) begin
        cnt_r[m] <= '0;
      end
      hold_until_r <= '0;
      hold_level_r <= '0;
      stopped_r    <= 1'b0;
      mot_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == rra_pkg::CFG_ENABLE) begin
          en_r <= cfg_data[0];
        end else begin
          sid_r <= cfg_data;
        end
      end
      cnt_r        <= cnt_nxt;
      hold_until_r <= hold_until_nxt;
      hold_level_r <= hold_level_nxt;
      stopped_r    <= stopped_nxt;
      mot_r        <= mot_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_motor       = out_motor_r;
  assign out_drive_level = out_level_r;
  assign out_shaking     = out_shaking_r;
  assign out_last        = out_last_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_cur <= CW'(rra_pkg::ENTRIES))
    else $error("entry count above table size");
  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == rra_pkg::OP_APPEND) |-> !stat.cnt_full)
    else $error("append into full table");
  a_out_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |=> (out_valid_r && out_last_r))
    else $error("tick results not back to back");

endmodule
`default_nettype wire
